[hdl/sweep_tone_generator_defines.svh]
// ----------------------------------------------------------------------------
// sweep_tone_generator_defines
// Assertion macros shared by the tone generator RTL.
// ----------------------------------------------------------------------------
`ifndef SWEEP_TONE_GENERATOR_DEFINES_SVH
`define SWEEP_TONE_GENERATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define STG_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define STG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/stg_pkg.sv]
// ----------------------------------------------------------------------------
// stg_pkg
// Constants, microcode format and sine ROM contents for the tone generator.
// ----------------------------------------------------------------------------
package stg_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int LENGTH_BITS    = 20;

  localparam int SINE_SIZE = 1 << SINE_ADDR_BITS;
  localparam int QUARTER   = SINE_SIZE / 4;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int SAMPLE_BITS    = 16;
  localparam int MAG_BITS       = 15;
  localparam int RAMP_BITS      = 25;
  localparam int PROD_A_BITS    = 30;
  localparam int PROD_BITS      = PROD_A_BITS + RAMP_BITS;

  localparam logic [RAMP_BITS-1:0] ONE_Q24  = RAMP_BITS'(1) << 24;
  localparam logic [MAG_BITS-1:0]  FULL_MAG = MAG_BITS'(32767);

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_INC  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INC_CHANGE = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP_STEP  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AMPLITUDE  = 3'd4;

  // microcode
  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_LOOKUP = 3'd1;
  localparam step_t STEP_GAIN   = 3'd2;
  localparam step_t STEP_ENV    = 3'd3;
  localparam step_t STEP_EMIT   = 3'd4;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_DD,   // d * d
    MUL_SA,   // |sine| * amplitude
    MUL_PE    // previous product * envelope
  } mul_sel_t;

  typedef enum logic [1:0] {
    C_NEVER,
    C_NO_INPUT,
    C_INACTIVE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic     in_rdy;
    logic     rom_rd;
    mul_sel_t mul_sel;
    logic     ld_env;
    logic     chk_active;
    logic     emit;
    cond_t    cond;
    step_t    target;
    logic     ret;      // fall-through returns to idle
  } ucode_t;

  typedef ucode_t ucode_rom_t [8];

  localparam ucode_rom_t UCODE = '{
    '{1'b1, 1'b0, MUL_NONE, 1'b0, 1'b0, 1'b0, C_NO_INPUT, STEP_IDLE, 1'b0},
    '{1'b0, 1'b1, MUL_DD,   1'b0, 1'b1, 1'b0, C_INACTIVE, STEP_EMIT, 1'b0},
    '{1'b0, 1'b0, MUL_SA,   1'b1, 1'b0, 1'b0, C_NEVER,    STEP_IDLE, 1'b0},
    '{1'b0, 1'b0, MUL_PE,   1'b0, 1'b0, 1'b0, C_NEVER,    STEP_IDLE, 1'b0},
    '{1'b0, 1'b0, MUL_NONE, 1'b0, 1'b0, 1'b1, C_OUT_BUSY, STEP_EMIT, 1'b1},
    '{1'b0, 1'b0, MUL_NONE, 1'b0, 1'b0, 1'b0, C_NEVER,    STEP_IDLE, 1'b1},
    '{1'b0, 1'b0, MUL_NONE, 1'b0, 1'b0, 1'b0, C_NEVER,    STEP_IDLE, 1'b1},
    '{1'b0, 1'b0, MUL_NONE, 1'b0, 1'b0, 1'b0, C_NEVER,    STEP_IDLE, 1'b1}
  };

  // sine ROM: magnitude only, sign is the top address bit
  typedef logic [MAG_BITS-1:0] sine_rom_t [SINE_SIZE];
  typedef int unsigned taylor_div_t [7];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam taylor_div_t TAYLOR_DIV = '{6, 20, 42, 72, 110, 156, 210};

  // 32767*sin(pi/2 * j/QUARTER), Q30 series to x^15, rounded half up
  function automatic logic [MAG_BITS-1:0] quarter_sine(input logic [31:0] j);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x    = (HALF_PI_Q30 * 64'(j)) / QUARTER;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n-1];
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_BITS-1:0];
  endfunction

  function automatic sine_rom_t build_sine();
    sine_rom_t                 t;
    logic [SINE_ADDR_BITS-1:0] ka;
    logic [31:0]               r;
    for (int k = 0; k < SINE_SIZE; k++) begin
      ka = SINE_ADDR_BITS'(k);
      r  = 32'(ka[SINE_ADDR_BITS-3:0]);
      if (ka[SINE_ADDR_BITS-2]) begin
        t[k] = quarter_sine(32'(QUARTER) - r);
      end else begin
        t[k] = quarter_sine(r);
      end
    end
    return t;
  endfunction

endpackage

[hdl/sweep_tone_generator.sv]
// ----------------------------------------------------------------------------
// sweep_tone_generator
// Sound effect synthesizer: a linear chirp with quadratic decay, one sample
// per request on the input channel.
//   cfg_*  : register writes (start_increment, increment_change, sample_count,
//            ramp_step, amplitude), always ready; write only while idle.
//   in_*   : one request per sample; in_restart=1 restarts the sound.
//   out_*  : one result per request: out_sample and out_finished.
// A small microcode ROM steps a single 30x25 multiplier through three
// products (d*d, |sine|*amplitude, gain*envelope); the sine ROM has a
// registered read. An active sample passes the lookup, gain, envelope
// and emit steps before it shows on out_valid; a finished or idle one
// goes from the lookup step straight to emit. The sequencer holds one
// request at a time and takes a new one only in its idle step.
// The next request is taken while a result still waits in the output
// register; if the receiver stalls, the program waits in its last step.
// Reset clears the control, configuration and sound state registers, not
// the datapath ones: the block is idle and answers finished until a restart.
// ----------------------------------------------------------------------------
`include "sweep_tone_generator_defines.svh"

module sweep_tone_generator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [stg_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_restart,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [stg_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic                                 out_finished
);
  import stg_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine();

  // configuration
  logic [31:0]            start_inc_r;
  logic [31:0]            inc_change_r;
  logic [LENGTH_BITS-1:0] count_r;
  logic [RAMP_BITS-1:0]   ramp_step_r;
  logic [MAG_BITS-1:0]    amplitude_r;

  // sound state
  logic [PHASE_BITS-1:0]  phase_acc_r;
  logic [PHASE_BITS-1:0]  phase_step_r;
  logic [RAMP_BITS-1:0]   ramp_pos_r;
  logic [LENGTH_BITS-1:0] sample_idx_r;
  logic                   active_r;

  // sequencer and datapath
  step_t                  pc_r;
  step_t                  pc_nxt;
  ucode_t                 uc;
  logic                   cond_hit;
  logic                   out_busy;
  logic                   emit_fire;
  logic                   accept;
  logic                   still_active;

  logic [MAG_BITS-1:0]    sine_mag_r;
  logic                   sine_neg_r;
  logic [RAMP_BITS-1:0]   env_r;
  logic [PROD_BITS-1:0]   prod_r;
  logic [PROD_A_BITS-1:0] mul_a;
  logic [RAMP_BITS-1:0]   mul_b;
  logic [RAMP_BITS-1:0]   decay;
  logic [SINE_ADDR_BITS-1:0] rom_addr;

  logic [PROD_A_BITS-1:0] scaled;
  logic [MAG_BITS-1:0]    q0;
  logic [15:0]            r0;
  logic [15:0]            q1;
  logic [15:0]            r1;
  logic [15:0]            quot;
  logic signed [SAMPLE_BITS-1:0] sample_val;
  logic [RAMP_BITS:0]     ramp_sum;

  logic                   out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                   out_finished_r;

  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_finished = out_finished_r;

  assign uc        = UCODE[pc_r];
  assign in_ready  = uc.in_rdy;
  assign accept    = in_valid && in_ready;
  assign out_busy  = out_valid_r && !out_ready;
  assign emit_fire = uc.emit && !out_busy;

  assign still_active = active_r && (sample_idx_r < count_r);

  always_comb begin
    case (uc.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_NO_INPUT: cond_hit = !in_valid;
      C_INACTIVE: cond_hit = !still_active;
      C_OUT_BUSY: cond_hit = out_busy;
      default:    cond_hit = 1'b0;
    endcase
    if (cond_hit) begin
      pc_nxt = uc.target;
    end else if (uc.ret) begin
      pc_nxt = STEP_IDLE;
    end else begin
      pc_nxt = pc_r + 3'd1;
    end
  end

  // ramp_pos never exceeds one, so no saturation needed here
  assign decay    = ONE_Q24 - ramp_pos_r;
  assign rom_addr = phase_acc_r[PHASE_BITS-1 -: SINE_ADDR_BITS];

  always_comb begin
    case (uc.mul_sel)
      MUL_DD: begin
        mul_a = PROD_A_BITS'(decay);
        mul_b = decay;
      end
      MUL_SA: begin
        mul_a = PROD_A_BITS'(sine_mag_r);
        mul_b = RAMP_BITS'(amplitude_r);
      end
      MUL_PE: begin
        mul_a = prod_r[PROD_A_BITS-1:0];
        mul_b = env_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // floor(scaled / 32767) by folding 2^15 = 32767 + 1 twice
  always_comb begin
    scaled = prod_r[24 +: PROD_A_BITS];
    q0     = scaled[PROD_A_BITS-1:MAG_BITS];
    r0     = {1'b0, scaled[MAG_BITS-1:0]} + {1'b0, q0};
    q1     = {1'b0, q0} + 16'(r0[15]);
    r1     = {1'b0, r0[14:0]} + 16'(r0[15]);
    quot   = (r1 >= {1'b0, FULL_MAG}) ? q1 + 16'd1 : q1;
    sample_val = sine_neg_r ? -signed'(quot) : signed'(quot);
  end

  assign ramp_sum = {1'b0, ramp_pos_r} + {1'b0, ramp_step_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r           <= STEP_IDLE;
      out_valid_r    <= 1'b0;
      out_finished_r <= 1'b0;
      start_inc_r    <= '0;
      inc_change_r   <= '0;
      count_r        <= '0;
      ramp_step_r    <= '0;
      amplitude_r    <= '0;
      phase_acc_r    <= '0;
      phase_step_r   <= '0;
      ramp_pos_r     <= '0;
      sample_idx_r   <= '0;
      active_r       <= 1'b0;
    end else begin
      pc_r <= pc_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_INC:  start_inc_r  <= cfg_data;
          REG_INC_CHANGE: inc_change_r <= cfg_data;
          REG_COUNT:      count_r      <= cfg_data[LENGTH_BITS-1:0];
          REG_RAMP_STEP:  ramp_step_r  <= cfg_data[RAMP_BITS-1:0];
          REG_AMPLITUDE:  amplitude_r  <= cfg_data[MAG_BITS-1:0];
          default: ;
        endcase
      end

      if (accept && in_restart) begin
        phase_acc_r  <= '0;
        ramp_pos_r   <= '0;
        sample_idx_r <= '0;
        phase_step_r <= start_inc_r[PHASE_BITS-1:0];
        active_r     <= 1'b1;
      end

      if (uc.chk_active) begin
        active_r <= still_active;
      end

      if (emit_fire && active_r) begin
        phase_acc_r  <= phase_acc_r + phase_step_r;
        phase_step_r <= phase_step_r + inc_change_r[PHASE_BITS-1:0];
        ramp_pos_r   <= (ramp_sum > {1'b0, ONE_Q24}) ? ONE_Q24 : ramp_sum[RAMP_BITS-1:0];
        sample_idx_r <= sample_idx_r + LENGTH_BITS'(1);
      end

      if (emit_fire) begin
        out_valid_r    <= 1'b1;
        out_finished_r <= !active_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (uc.rom_rd) begin
      sine_mag_r <= SINE_ROM[rom_addr];
      sine_neg_r <= rom_addr[SINE_ADDR_BITS-1];
    end
    if (uc.ld_env) begin
      env_r <= prod_r[24 +: RAMP_BITS];
    end
    if (uc.mul_sel != MUL_NONE) begin
      prod_r <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    end
    if (emit_fire) begin
      out_sample_r <= active_r ? sample_val : '0;
    end
  end

  `STG_ASSERT_IMPLY(a_finished_silent, out_valid_r && out_finished_r, out_sample_r == '0, "finished result with nonzero sample")
  `STG_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, pc_r == STEP_LOOKUP, "request accepted but program did not start")
  `STG_ASSERT_IMPLY(a_ramp_bound, 1'b1, ramp_pos_r <= ONE_Q24, "ramp position beyond one")
  `STG_ASSERT_NEXT(a_emit_holds, uc.emit && out_busy, pc_r == STEP_EMIT, "program left emit step while output stalled")

endmodule
